// ===== rtl/tsce_pkg.sv =====
// Types and constants shared by the TCP server connection engine.
// No dependencies; compiled before all other files.
`timescale 1ns / 1ps
package tsce_pkg;

   localparam logic [5:0]  FL_FIN = 6'h01;
   localparam logic [5:0]  FL_SYN = 6'h02;
   localparam logic [5:0]  FL_RST = 6'h04;
   localparam logic [5:0]  FL_ACK = 6'h10;
   localparam logic [12:0] WINDOW_OPEN = 13'd4096;
   localparam logic [16:0] IP_HDR_BYTES = 17'd20;
   localparam logic [3:0]  MAX_CLOSES = 4'd8;
   localparam logic [15:0] LISTEN_PORT_RESET = 16'd80;
   localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd30000000;

   localparam logic [7:0] CSR_LISTEN_PORT = 8'd0;
   localparam logic [7:0] CSR_IDLE_TIMEOUT = 8'd1;

   localparam logic OP_SEGMENT = 1'b0;
   localparam logic OP_SWEEP = 1'b1;

   typedef enum logic [1:0] {
      MODE_FREE        = 2'd0,
      MODE_SYN_RCVD    = 2'd1,
      MODE_ESTABLISHED = 2'd2,
      MODE_FIN_WAIT    = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LREAD,
      ST_LCHK,
      ST_MISS,
      ST_ACT,
      ST_FIN,
      ST_SREAD,
      ST_SCHK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] peer_addr;
      logic [15:0] peer_port;
      logic [31:0] lseq;
      logic [31:0] rseq;
      logic [31:0] last_seen;
   } conn_entry_type;

   typedef struct packed {
      logic        op;
      logic [31:0] src_ip;
      logic [15:0] sender_port;
      logic [15:0] target_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
      logic [5:0]  flags_in;
      logic [31:0] now_us;
   } item_type;

   typedef struct packed {
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [15:0] own_port;
      logic [31:0] out_seq;
      logic [31:0] out_ack;
      logic [5:0]  out_flags;
      logic [12:0] window;
      logic [2:0]  slot;
      logic [15:0] accepted_len;
      logic        last;
   } rsp_type;

   function automatic rsp_type make_rst(logic [31:0] ip, logic [15:0] pport,
                                        logic [15:0] oport, logic [31:0] sq,
                                        logic [31:0] ak);
      rsp_type r;
      r.peer_ip      = ip;
      r.peer_port    = pport;
      r.own_port     = oport;
      r.out_seq      = sq;
      r.out_ack      = ak;
      r.out_flags    = FL_RST | FL_ACK;
      r.window       = 13'd0;
      r.slot         = 3'd0;
      r.accepted_len = 16'd0;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic rsp_type make_entry(conn_entry_type e, logic [15:0] oport,
                                          logic [31:0] sq, logic [31:0] ak,
                                          logic [5:0] fl, logic [2:0] slot,
                                          logic [15:0] alen);
      rsp_type r;
      r.peer_ip      = e.peer_addr;
      r.peer_port    = e.peer_port;
      r.own_port     = oport;
      r.out_seq      = sq;
      r.out_ack      = ak;
      r.out_flags    = fl;
      r.window       = WINDOW_OPEN;
      r.slot         = slot;
      r.accepted_len = alen;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

// ===== rtl/tsce_if.sv =====
// Channel interfaces of the TCP server connection engine: segment input,
// segment output and register writes. No dependencies.
`timescale 1ns / 1ps
interface tsce_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] src_ip;
   logic [15:0] sender_port;
   logic [15:0] target_port;
   logic [31:0] seq_in;
   logic [31:0] ack_in;
   logic [5:0]  flags_in;
   logic [15:0] ip_length;
   logic [3:0]  header_words;
   logic [31:0] now_us;
   modport source (output valid, op, src_ip, sender_port, target_port, seq_in, ack_in,
                   flags_in, ip_length, header_words, now_us, input ready);
   modport sink (input valid, op, src_ip, sender_port, target_port, seq_in, ack_in,
                 flags_in, ip_length, header_words, now_us, output ready);
endinterface

interface tsce_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] peer_ip;
   logic [15:0] peer_port;
   logic [15:0] own_port;
   logic [31:0] out_seq;
   logic [31:0] out_ack;
   logic [5:0]  out_flags;
   logic [12:0] window;
   logic [2:0]  slot;
   logic [15:0] accepted_len;
   logic        last;
   modport source (output valid, peer_ip, peer_port, own_port, out_seq, out_ack,
                   out_flags, window, slot, accepted_len, last, input ready);
   modport sink (input valid, peer_ip, peer_port, own_port, out_seq, out_ack,
                 out_flags, window, slot, accepted_len, last, output ready);
endinterface

interface tsce_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tcp_server_connection_engine.sv =====
// Server-side TCP connection table with passive open and idle sweep.
// Depends on tsce_pkg and the interfaces in tsce_if.sv.
//
// Usage:
//   req_bus carries one received segment header (op 0) or an idle sweep (op 1).
//   rsp_bus returns the segments to send; last marks the final one of an item.
//   csr_bus writes listen_port (index 0) and idle_timeout_us (index 1); write
//   only while the block is idle.
// Sequencing:
//   Connection state lives in a single-port-read memory with a registered
//   read; each table entry is read, then checked. A segment's lookup scans the
//   table and may answer with both a payload acknowledge and a FIN; a
//   wrong-port segment skips the table, and a sweep scans it until its end or
//   MAX_CLOSES closes. A result that rsp_bus holds back can stall the
//   sequencer. One item is in work at a time; req_bus.ready is high only
//   between items.
// Reset:
//   All entries free, listen_port 80, idle_timeout_us 30000000.
// Stall:
//   An output register and one pending result hold the results; when rsp_bus
//   is stalled the sequencer holds only where it must move the pending result on, until the output register frees up.
`timescale 1ns / 1ps
module tcp_server_connection_engine #(
   parameter int CONNECTIONS = 8
) (
   input logic        clock,
   input logic        reset,
   tsce_req_if.sink   req_bus,
   tsce_rsp_if.source rsp_bus,
   tsce_csr_if.sink   csr_bus
);

   localparam int IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(CONNECTIONS - 1);

   tsce_pkg::state_type state_ff, state_in;
   tsce_pkg::item_type  item_ff, item_in;
   logic [15:0]         plen_ff, plen_in;
   logic [IW-1:0]       idx_ff, idx_in, hit_ff, hit_in, free_ff, free_in;
   logic                free_vld_ff, free_vld_in;
   logic [3:0]          closes_ff, closes_in;
   tsce_pkg::mode_type  mode_ff [CONNECTIONS];
   logic [15:0]         listen_ff;
   logic [31:0]         timeout_ff;

   tsce_pkg::conn_entry_type conn_mem [CONNECTIONS];
   tsce_pkg::conn_entry_type rd_ff;

   tsce_pkg::rsp_type pend_ff, out_ff, fin_res_ff, fin_res_in, gen_res, push_res;
   logic              pend_vld_ff, out_vld_ff;

   logic                     accept, can_take, gen, push, push_last, rd_en;
   logic                     wr_en, mode_we;
   logic [IW-1:0]            wr_addr;
   tsce_pkg::conn_entry_type wr_data;
   tsce_pkg::mode_type       mode_wd;

   logic               match, expired, acc, has_fin, has_ack;
   logic [16:0]        hdr_len;
   logic [15:0]        plen_calc;
   logic [31:0]        rseq1, idle_time;
   tsce_pkg::mode_type hit_mode;

   assign accept   = req_bus.valid && req_bus.ready;
   assign can_take = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == tsce_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign hdr_len   = tsce_pkg::IP_HDR_BYTES + {11'd0, req_bus.header_words, 2'b00};
   assign plen_calc = ({1'b0, req_bus.ip_length} > hdr_len) ?
                      16'({1'b0, req_bus.ip_length} - hdr_len) : 16'd0;

   assign match = (mode_ff[idx_ff] != tsce_pkg::MODE_FREE) &&
                  (rd_ff.peer_addr == item_ff.src_ip) &&
                  (rd_ff.peer_port == item_ff.sender_port);
   assign idle_time = item_ff.now_us - rd_ff.last_seen;
   assign expired = (mode_ff[idx_ff] != tsce_pkg::MODE_FREE) && (idle_time > timeout_ff);
   assign hit_mode = mode_ff[hit_ff];
   assign acc     = (plen_ff != 16'd0) && (item_ff.seq_in == rd_ff.rseq);
   assign rseq1   = acc ? rd_ff.rseq + {16'd0, plen_ff} : rd_ff.rseq;
   assign has_fin = (item_ff.flags_in & tsce_pkg::FL_FIN) != 6'd0;
   assign has_ack = (item_ff.flags_in & tsce_pkg::FL_ACK) != 6'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsce_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_bus.op == tsce_pkg::OP_SWEEP) begin
                  state_in = tsce_pkg::ST_SREAD;
               end else if (req_bus.target_port != listen_ff) begin
                  state_in = tsce_pkg::ST_FLUSH;
               end else begin
                  state_in = tsce_pkg::ST_LREAD;
               end
            end
         end
         tsce_pkg::ST_LREAD: state_in = tsce_pkg::ST_LCHK;
         tsce_pkg::ST_LCHK: begin
            if (match) begin
               state_in = tsce_pkg::ST_ACT;
            end else if (idx_ff == LAST_IDX) begin
               state_in = tsce_pkg::ST_MISS;
            end else begin
               state_in = tsce_pkg::ST_LREAD;
            end
         end
         tsce_pkg::ST_MISS: state_in = tsce_pkg::ST_FLUSH;
         tsce_pkg::ST_ACT: begin
            if (hit_mode == tsce_pkg::MODE_ESTABLISHED && acc && has_fin &&
                (item_ff.flags_in & tsce_pkg::FL_RST) == 6'd0) begin
               state_in = tsce_pkg::ST_FIN;
            end else begin
               state_in = tsce_pkg::ST_FLUSH;
            end
         end
         tsce_pkg::ST_FIN: begin
            if (can_take) state_in = tsce_pkg::ST_FLUSH;
         end
         tsce_pkg::ST_SREAD: state_in = tsce_pkg::ST_SCHK;
         tsce_pkg::ST_SCHK: begin
            if (!expired || !pend_vld_ff || can_take) begin
               if (idx_ff == LAST_IDX ||
                   (expired && closes_ff + 4'd1 == tsce_pkg::MAX_CLOSES)) begin
                  state_in = tsce_pkg::ST_FLUSH;
               end else begin
                  state_in = tsce_pkg::ST_SREAD;
               end
            end
         end
         tsce_pkg::ST_FLUSH: begin
            if (!pend_vld_ff || can_take) state_in = tsce_pkg::ST_IDLE;
         end
         default: state_in = tsce_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      item_in     = item_ff;
      plen_in     = plen_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      free_vld_in = free_vld_ff;
      closes_in   = closes_ff;
      fin_res_in  = fin_res_ff;
      gen         = 1'b0;
      gen_res     = fin_res_ff;
      push        = 1'b0;
      push_last   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = hit_ff;
      wr_data     = rd_ff;
      mode_we     = 1'b0;
      mode_wd     = tsce_pkg::MODE_FREE;
      case (state_ff)
         tsce_pkg::ST_IDLE: begin
            if (accept) begin
               item_in.op          = req_bus.op;
               item_in.src_ip      = req_bus.src_ip;
               item_in.sender_port = req_bus.sender_port;
               item_in.target_port = req_bus.target_port;
               item_in.seq_in      = req_bus.seq_in;
               item_in.ack_in      = req_bus.ack_in;
               item_in.flags_in    = req_bus.flags_in;
               item_in.now_us      = req_bus.now_us;
               plen_in     = plen_calc;
               idx_in      = '0;
               free_vld_in = 1'b0;
               closes_in   = 4'd0;
               if (req_bus.op == tsce_pkg::OP_SEGMENT &&
                   req_bus.target_port != listen_ff) begin
                  gen     = 1'b1;
                  gen_res = tsce_pkg::make_rst(req_bus.src_ip, req_bus.sender_port,
                                               req_bus.target_port, req_bus.ack_in,
                                               req_bus.seq_in + 32'd1);
               end
            end
         end
         tsce_pkg::ST_LREAD, tsce_pkg::ST_SREAD: rd_en = 1'b1;
         tsce_pkg::ST_LCHK: begin
            if (!free_vld_ff && mode_ff[idx_ff] == tsce_pkg::MODE_FREE) begin
               free_in     = idx_ff;
               free_vld_in = 1'b1;
            end
            if (match) begin
               hit_in = idx_ff;
            end else if (idx_ff != LAST_IDX) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tsce_pkg::ST_MISS: begin
            gen = 1'b1;
            if ((item_ff.flags_in & tsce_pkg::FL_SYN) == 6'd0) begin
               gen_res = tsce_pkg::make_rst(item_ff.src_ip, item_ff.sender_port,
                                            item_ff.target_port, item_ff.ack_in,
                                            item_ff.seq_in + 32'd1);
            end else if (!free_vld_ff) begin
               gen_res = tsce_pkg::make_rst(item_ff.src_ip, item_ff.sender_port,
                                            item_ff.target_port, 32'd0,
                                            item_ff.seq_in + 32'd1);
            end else begin
               wr_en             = 1'b1;
               wr_addr           = free_ff;
               wr_data.peer_addr = item_ff.src_ip;
               wr_data.peer_port = item_ff.sender_port;
               wr_data.lseq      = item_ff.now_us + 32'd1;
               wr_data.rseq      = item_ff.seq_in + 32'd1;
               wr_data.last_seen = item_ff.now_us;
               mode_we           = 1'b1;
               mode_wd           = tsce_pkg::MODE_SYN_RCVD;
               gen_res = tsce_pkg::make_entry(wr_data, listen_ff, item_ff.now_us,
                                              item_ff.seq_in + 32'd1,
                                              tsce_pkg::FL_SYN | tsce_pkg::FL_ACK,
                                              3'(free_ff), 16'd0);
            end
         end
         tsce_pkg::ST_ACT: begin
            wr_en             = 1'b1;
            wr_data.last_seen = item_ff.now_us;
            if ((item_ff.flags_in & tsce_pkg::FL_RST) != 6'd0) begin
               mode_we = 1'b1;
               mode_wd = tsce_pkg::MODE_FREE;
            end else begin
               case (hit_mode)
                  tsce_pkg::MODE_SYN_RCVD: begin
                     if (has_ack) begin
                        mode_we = 1'b1;
                        mode_wd = tsce_pkg::MODE_ESTABLISHED;
                     end
                  end
                  tsce_pkg::MODE_ESTABLISHED: begin
                     wr_data.rseq = has_fin ? rseq1 + 32'd1 : rseq1;
                     wr_data.lseq = has_fin ? rd_ff.lseq + 32'd1 : rd_ff.lseq;
                     fin_res_in = tsce_pkg::make_entry(rd_ff, listen_ff, rd_ff.lseq,
                                                       rseq1 + 32'd1,
                                                       tsce_pkg::FL_FIN | tsce_pkg::FL_ACK,
                                                       3'(hit_ff), 16'd0);
                     if (has_fin) begin
                        mode_we = 1'b1;
                        mode_wd = tsce_pkg::MODE_FREE;
                     end
                     if (acc) begin
                        gen     = 1'b1;
                        gen_res = tsce_pkg::make_entry(rd_ff, listen_ff, rd_ff.lseq, rseq1,
                                                       tsce_pkg::FL_ACK, 3'(hit_ff),
                                                       plen_ff);
                     end else if (has_fin) begin
                        gen     = 1'b1;
                        gen_res = fin_res_in;
                     end
                  end
                  tsce_pkg::MODE_FIN_WAIT: begin
                     if (has_fin) begin
                        wr_data.rseq = rd_ff.rseq + 32'd1;
                        mode_we      = 1'b1;
                        mode_wd      = tsce_pkg::MODE_FREE;
                        gen          = 1'b1;
                        gen_res = tsce_pkg::make_entry(rd_ff, listen_ff, rd_ff.lseq,
                                                       rd_ff.rseq + 32'd1,
                                                       tsce_pkg::FL_ACK, 3'(hit_ff),
                                                       16'd0);
                     end else if (has_ack) begin
                        mode_we = 1'b1;
                        mode_wd = tsce_pkg::MODE_FREE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         tsce_pkg::ST_FIN: begin
            if (can_take) begin
               gen  = 1'b1;
               push = 1'b1;
            end
         end
         tsce_pkg::ST_SCHK: begin
            if (!expired || !pend_vld_ff || can_take) begin
               if (expired) begin
                  gen          = 1'b1;
                  push         = pend_vld_ff;
                  gen_res = tsce_pkg::make_entry(rd_ff, listen_ff, rd_ff.lseq, rd_ff.rseq,
                                                 tsce_pkg::FL_FIN | tsce_pkg::FL_ACK,
                                                 3'(idx_ff), 16'd0);
                  wr_en        = 1'b1;
                  wr_addr      = idx_ff;
                  wr_data.lseq = rd_ff.lseq + 32'd1;
                  mode_we      = 1'b1;
                  mode_wd      = tsce_pkg::MODE_FIN_WAIT;
                  closes_in    = closes_ff + 4'd1;
               end
               if (idx_ff != LAST_IDX) idx_in = idx_ff + 1'b1;
            end
         end
         tsce_pkg::ST_FLUSH: begin
            if (pend_vld_ff && can_take) begin
               push      = 1'b1;
               push_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      push_res      = pend_ff;
      push_res.last = push_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tsce_pkg::ST_IDLE;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         listen_ff   <= tsce_pkg::LISTEN_PORT_RESET;
         timeout_ff  <= tsce_pkg::IDLE_TIMEOUT_RESET;
         free_vld_ff <= 1'b0;
         closes_ff   <= 4'd0;
         idx_ff      <= '0;
         for (int i = 0; i < CONNECTIONS; i++) mode_ff[i] <= tsce_pkg::MODE_FREE;
      end else begin
         state_ff    <= state_in;
         free_vld_ff <= free_vld_in;
         closes_ff   <= closes_in;
         idx_ff      <= idx_in;
         if (mode_we) mode_ff[wr_addr] <= mode_wd;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               tsce_pkg::CSR_LISTEN_PORT:  listen_ff  <= csr_bus.data[15:0];
               tsce_pkg::CSR_IDLE_TIMEOUT: timeout_ff <= csr_bus.data;
               default: ;
            endcase
         end
         if (gen) begin
            pend_vld_ff <= 1'b1;
         end else if (push) begin
            pend_vld_ff <= 1'b0;
         end
         if (push) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      plen_ff    <= plen_in;
      hit_ff     <= hit_in;
      free_ff    <= free_in;
      fin_res_ff <= fin_res_in;
      if (gen) pend_ff <= gen_res;
      if (push) out_ff <= push_res;
   end

   always_ff @(posedge clock) begin
      if (wr_en) conn_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= conn_mem[idx_ff];
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.peer_ip      = out_ff.peer_ip;
   assign rsp_bus.peer_port    = out_ff.peer_port;
   assign rsp_bus.own_port     = out_ff.own_port;
   assign rsp_bus.out_seq      = out_ff.out_seq;
   assign rsp_bus.out_ack      = out_ff.out_ack;
   assign rsp_bus.out_flags    = out_ff.out_flags;
   assign rsp_bus.window       = out_ff.window;
   assign rsp_bus.slot         = out_ff.slot;
   assign rsp_bus.accepted_len = out_ff.accepted_len;
   assign rsp_bus.last         = out_ff.last;

endmodule

// ===== rtl/tsce_checker.sv =====
// Port-level checks for tcp_server_connection_engine, attached by bind.
// Depends on tsce_pkg and the top level's interface ports.
`timescale 1ns / 1ps
module tsce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_flags,
   input logic [12:0] rsp_window,
   input logic [2:0]  rsp_slot,
   input logic [15:0] rsp_len,
   input logic        rsp_last
);

   // hold a stalled transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flags) && $stable(rsp_last))
      else $error("stalled result changed");

   // drop ready after taking an item
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_rst_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window == 13'd0 |->
         rsp_flags == (tsce_pkg::FL_RST | tsce_pkg::FL_ACK) && rsp_slot == 3'd0 &&
         rsp_len == 16'd0 && rsp_last)
      else $error("malformed reset segment");

   a_len_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_len != 16'd0 |->
         rsp_flags == tsce_pkg::FL_ACK && rsp_window == tsce_pkg::WINDOW_OPEN)
      else $error("payload acknowledge malformed");

endmodule

bind tcp_server_connection_engine tsce_checker u_tsce_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_flags  (rsp_bus.out_flags),
   .rsp_window (rsp_bus.window),
   .rsp_slot   (rsp_bus.slot),
   .rsp_len    (rsp_bus.accepted_len),
   .rsp_last   (rsp_bus.last)
);
